// ----- rtl/rwg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwg_pkg - shared types and constants of the reference waveform generator
// Mode codes, register indexes, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package rwg_pkg;

    // Shared multiplier operand width and product width
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration data width: widest register
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_STEPS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET    = 3'd5;

    // Waveform modes
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;
    localparam logic [1:0] MODE_SAW    = 2'd2;

    // Sine table construction: pi/2 in Q2.30 and one in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] SINE_FULL   = 64'd32767;

    // Ramp accumulator, Q2.24
    localparam int RAMP_W = 26;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INDEX = 6'b000010,
        ST_ROM   = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_SUM   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage : rwg_pkg
`default_nettype wire

// ----- rtl/rwg_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwg_mul - shared unsigned multiplier
// One 32 x 32 bit multiplication per cycle with a registered product.
// ----------------------------------------------------------------------------
module rwg_mul
    import rwg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MUL_W-1:0]  op_a,
    input  wire logic [MUL_W-1:0]  op_b,
    output logic      [PROD_W-1:0] product
);

    logic [PROD_W-1:0] product_reg;

    // Register the full product every cycle
    always_ff @(posedge clk)
    begin
        product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = product_reg;

endmodule : rwg_mul
`default_nettype wire

// ----- rtl/reference_waveform_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reference_waveform_generator - sine, square and sawtooth reference source
// Each input transaction is one sample tick and yields one output sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries sample_index; m_tdata carries wave_value and m_tuser the
//   clipped flag. Registers are written through cfg_wr_en/cfg_index/cfg_data
//   while no sample is in flight; writes to indexes beyond dc_offset are
//   dropped.
// Sequence (accept edge to m_tvalid):
//   sine: index, table read, scale, sum, output; sawtooth: sum, output;
//   square and unused mode: output. The sine and sawtooth steps follow the
//   passes through the single shared 32 x 32 multiplier (phase, table index,
//   amplitude for sine; amplitude times ramp for sawtooth) and the registered
//   table read. s_tready is high only while the sequencer is idle.
// Reset:
//   rst_n clears the counters, the ramp accumulator and the handshake and
//   loads the register defaults.
// Stall:
//   a finished sample waits in the output register; the next transaction is
//   accepted meanwhile, and its result is held until m_tready frees the slot.
// ----------------------------------------------------------------------------
module reference_waveform_generator
    import rwg_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 256,
    parameter int PERIOD_WIDTH       = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream; s_tdata: [31:0] sample_index
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,
    // Output stream; m_tdata: [15:0] wave_value
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [15:0]            m_tdata,
    // m_tuser: [0] clipped
    output logic      [0:0]             m_tuser,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int CW = PERIOD_WIDTH + 1;
    localparam int SUM_W = 20;

    typedef logic [14:0] rom_t [SINE_TABLE_ENTRIES + 1];

    // Quarter-wave sine table, Q1.15, built by a Taylor series in Q2.30
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++)
        begin
            x  = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
            x2 = (x * x) >> 30;
            t  = x;
            s  = x;
            t  = ((t * x2) >> 30) / 64'd6;
            s  = (s >= t) ? s - t : 64'd0;
            t  = ((t * x2) >> 30) / 64'd20;
            s  = s + t;
            t  = ((t * x2) >> 30) / 64'd42;
            s  = (s >= t) ? s - t : 64'd0;
            t  = ((t * x2) >> 30) / 64'd72;
            s  = s + t;
            t  = ((t * x2) >> 30) / 64'd110;
            s  = (s >= t) ? s - t : 64'd0;
            q  = (s * SINE_FULL + (ONE_Q30 >> 1)) >> 30;
            if (q > SINE_FULL)
            begin
                q = SINE_FULL;
            end
            rom[k] = 15'(q);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Configuration registers
    logic [1:0]  wave_mode_reg;
    logic [23:0] period_steps_reg;
    logic [23:0] ramp_step_reg;
    logic [31:0] phase_step_reg;
    logic [14:0] amplitude_reg;
    logic [15:0] dc_offset_reg;

    // Waveform state
    logic [CW-1:0]     step_count_reg;
    logic [CW-1:0]     step_count_next;
    logic [RAMP_W-1:0] ramp_acc_reg;
    logic [RAMP_W-1:0] ramp_acc_next;

    // Sequencer and datapath registers
    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  quad_reg;
    logic [14:0] rom_reg;
    logic        saw_zero_reg;
    logic [15:0] res_value_reg;
    logic        res_clip_reg;
    logic [15:0] out_value_reg;
    logic        out_clip_reg;
    logic        out_valid_reg;

    // Shared multiplier
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    rwg_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    logic                    s_accept;
    logic                    out_free;
    logic [PERIOD_WIDTH-1:0] period_w;
    logic                    sq_high;
    logic                    sq_wrap;
    logic                    saw_in_range;
    logic [CW-1:0]           count_base;
    logic [RAMP_W-1:0]       ramp_base;
    logic [RAMP_W:0]         ramp_sum;
    logic [AW-1:0]           rom_k;
    logic [AW-1:0]           rom_addr;
    logic [30:0]             sin_round;
    logic [15:0]             sin_mag;
    logic [41:0]             saw_round;
    logic [17:0]             saw_mag;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    logic [15:0]             sat_value;
    logic                    sat_clip;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign period_w = PERIOD_WIDTH'(period_steps_reg);

    // Square and sawtooth period decisions
    assign sq_high      = {step_count_reg, 1'b0} <= {2'b00, period_w};
    assign sq_wrap      = step_count_reg >= {1'b0, period_w};
    assign saw_in_range = step_count_reg <= {1'b0, period_w};

    // Counter and ramp advance for the active mode
    always_comb
    begin
        if (wave_mode_reg == MODE_SQUARE)
        begin
            count_base = sq_wrap ? '0 : step_count_reg;
        end
        else
        begin
            count_base = saw_in_range ? step_count_reg : '0;
        end
        step_count_next = count_base + CW'(1);
        ramp_base       = saw_in_range ? ramp_acc_reg : '0;
        ramp_sum        = {1'b0, ramp_base} + (RAMP_W + 1)'(ramp_step_reg);
        ramp_acc_next   = ramp_sum[RAMP_W] ? '1 : ramp_sum[RAMP_W-1:0];
    end

    // Select multiplier operands by sequencer step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (wave_mode_reg == MODE_SAW)
                begin
                    mul_a = MUL_W'(amplitude_reg);
                    mul_b = MUL_W'(ramp_acc_reg);
                end
                else
                begin
                    mul_a = s_tdata;
                    mul_b = phase_step_reg;
                end
            end
            ST_INDEX:
            begin
                mul_a = {2'b00, prod[29:0]};
                mul_b = MUL_W'(SINE_TABLE_ENTRIES);
            end
            ST_SCALE:
            begin
                mul_a = MUL_W'(amplitude_reg);
                mul_b = MUL_W'(rom_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Table address: mirror in the odd quadrants
    assign rom_k    = prod[30 +: AW];
    assign rom_addr = quad_reg[0] ? AW'(SINE_TABLE_ENTRIES) - rom_k : rom_k;

    // Scale, add offset and saturate
    always_comb
    begin
        sin_round = prod[30:0] + 31'd16384;
        sin_mag   = sin_round[30:15];
        saw_round = prod[41:0] + (42'd1 << 23);
        saw_mag   = saw_round[41:24];
        if (wave_mode_reg == MODE_SAW)
        begin
            term = saw_zero_reg ? '0 : SUM_W'({2'b00, saw_mag});
        end
        else
        begin
            term = quad_reg[1] ? -SUM_W'({4'b0000, sin_mag}) : SUM_W'({4'b0000, sin_mag});
        end
        sum = term + {{(SUM_W - 16){dc_offset_reg[15]}}, dc_offset_reg};
        if (sum > SUM_W'(32767))
        begin
            sat_value = 16'h7FFF;
            sat_clip  = 1'b1;
        end
        else if (sum < -SUM_W'(32768))
        begin
            sat_value = 16'h8000;
            sat_clip  = 1'b1;
        end
        else
        begin
            sat_value = sum[15:0];
            sat_clip  = 1'b0;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (wave_mode_reg)
                        MODE_SINE: state_next = ST_INDEX;
                        MODE_SAW:  state_next = ST_SUM;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_INDEX: state_next = ST_ROM;
            ST_ROM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg    <= MODE_SINE;
            period_steps_reg <= 24'd1000;
            ramp_step_reg    <= 24'd16777;
            phase_step_reg   <= 32'd4294967;
            amplitude_reg    <= 15'd16384;
            dc_offset_reg    <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WAVE_MODE:    wave_mode_reg    <= cfg_data[1:0];
                REG_PERIOD_STEPS: period_steps_reg <= cfg_data[23:0];
                REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[23:0];
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[14:0];
                REG_DC_OFFSET:    dc_offset_reg    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Sequencer, waveform state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_count_reg <= '0;
            ramp_acc_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_accept && wave_mode_reg == MODE_SQUARE)
            begin
                step_count_reg <= step_count_next;
            end
            if (s_accept && wave_mode_reg == MODE_SAW)
            begin
                step_count_reg <= step_count_next;
                ramp_acc_reg   <= ramp_acc_next;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            saw_zero_reg <= !saw_in_range;
            case (wave_mode_reg)
                MODE_SQUARE:
                begin
                    res_value_reg <= sq_high ? {1'b0, amplitude_reg} : 16'd0;
                    res_clip_reg  <= 1'b0;
                end
                MODE_SINE, MODE_SAW: ;
                default:
                begin
                    res_value_reg <= 16'd0;
                    res_clip_reg  <= 1'b0;
                end
            endcase
        end
        if (state_reg == ST_INDEX)
        begin
            quad_reg <= prod[31:30];
        end
        if (state_reg == ST_ROM)
        begin
            rom_reg <= SINE_ROM[rom_addr];
        end
        if (state_reg == ST_SUM)
        begin
            res_value_reg <= sat_value;
            res_clip_reg  <= sat_clip;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_value_reg <= res_value_reg;
            out_clip_reg  <= res_clip_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_clip_reg;

endmodule : reference_waveform_generator
`default_nettype wire

// ----- tb/sv/tb_reference_waveform_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reference_waveform_generator - self-checking bench for the waveform source
// Drives sample ticks and register writes into the generator and predicts every
// output sample (sine table lookup, square and sawtooth counters, saturation)
// with a scoreboard. Both stream sides idle and stall at random. Registers
// change only between phases, once every sample in flight has come back.
// ----------------------------------------------------------------------------
module tb_reference_waveform_generator;
    import rwg_pkg::*;

    localparam int          SINE_ENTRIES = 256;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 1500000;
    localparam int          MAX_REPORTS  = 200;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint      RAMP_LIMIT   = (64'sd1 <<< RAMP_W) - 1;

    typedef struct packed {
        logic [15:0] value;
        logic        clipped;
    } wave_sample_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors registers and counters, queues predicted samples
    // ------------------------------------------------------------------------
    class wave_scoreboard;
        logic [1:0]         mode;
        logic [23:0]        period;
        logic [23:0]        ramp_inc;
        logic [31:0]        phase_inc;
        logic [14:0]        amp;
        logic signed [15:0] offset;
        logic [24:0]        step_count;
        logic [25:0]        ramp_acc;
        longint             sine_rom[SINE_ENTRIES + 1];
        wave_sample_t       expected_q[$];
        int                 errors;

        function new();
            longint unsigned x, x2, term, sum, q;
            mode       = MODE_SINE;
            period     = 24'd1000;
            ramp_inc   = 24'd16777;
            phase_inc  = 32'd4294967;
            amp        = 15'd16384;
            offset     = 16'sd0;
            step_count = '0;
            ramp_acc   = '0;
            errors     = 0;
            // Quarter-wave sine, Taylor series to x^11 in Q2.30, then Q1.15
            for (int k = 0; k <= SINE_ENTRIES; k++)
            begin
                x    = (HALF_PI_Q30 * k) / SINE_ENTRIES;
                x2   = (x * x) >> 30;
                term = x;
                sum  = x;
                for (int i = 1; i <= 5; i++)
                begin
                    term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
                    if (i % 2 == 1)
                        sum = (sum >= term) ? sum - term : 0;
                    else
                        sum = sum + term;
                end
                q = (sum * SINE_FULL + (ONE_Q30 >> 1)) >> 30;
                if (q > SINE_FULL)
                    q = SINE_FULL;
                sine_rom[k] = longint'(q);
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_WAVE_MODE:    mode      = data[1:0];
                REG_PERIOD_STEPS: period    = data[23:0];
                REG_RAMP_STEP:    ramp_inc  = data[23:0];
                REG_PHASE_STEP:   phase_inc = data[31:0];
                REG_AMPLITUDE:    amp       = data[14:0];
                REG_DC_OFFSET:    offset    = data[15:0];
                default: ;
            endcase
        endfunction

        // Clamp to 16 signed bits and flag the clamp
        function wave_sample_t saturate(longint v);
            wave_sample_t res;
            res.clipped = 1'b0;
            if (v > 32767)
            begin
                v = 32767;
                res.clipped = 1'b1;
            end
            else if (v < -32768)
            begin
                v = -32768;
                res.clipped = 1'b1;
            end
            res.value = v[15:0];
            return res;
        endfunction

        // Advance the mirrored state by one tick and queue the sample it gives
        function void note_sample(logic [31:0] sample_index);
            wave_sample_t res;
            logic [31:0]  phase;
            longint       s, mag, scaled, v, period_l, count_l, acc_l, k;
            period_l = longint'(period);
            count_l  = longint'(step_count);
            res      = '0;
            case (mode)
                MODE_SINE:
                begin
                    phase = sample_index * phase_inc;
                    k     = (longint'(phase[29:0]) * SINE_ENTRIES) >> 30;
                    // Odd quadrants mirror the index, upper half negates
                    s = phase[30] ? sine_rom[SINE_ENTRIES - k] : sine_rom[k];
                    if (phase[31])
                        s = -s;
                    mag    = (s < 0) ? -s : s;
                    scaled = (longint'(amp) * mag + 16384) >> 15;
                    if (s < 0)
                        scaled = -scaled;
                    res = saturate(scaled + longint'(offset));
                end
                MODE_SQUARE:
                begin
                    v = (2 * count_l <= period_l) ? longint'(amp) : 0;
                    if (count_l >= period_l)
                        count_l = 0;
                    step_count = count_l[24:0] + 25'd1;
                    res = saturate(v);
                end
                MODE_SAW:
                begin
                    if (count_l <= period_l)
                        v = ((longint'(amp) * longint'(ramp_acc) + (64'sd1 <<< 23)) >> 24)
                            + longint'(offset);
                    else
                    begin
                        ramp_acc = '0;
                        count_l  = 0;
                        v        = longint'(offset);
                    end
                    // Ramp saturates instead of wrapping
                    acc_l = longint'(ramp_acc) + longint'(ramp_inc);
                    if (acc_l > RAMP_LIMIT)
                        acc_l = RAMP_LIMIT;
                    ramp_acc   = acc_l[25:0];
                    step_count = count_l[24:0] + 25'd1;
                    res = saturate(v);
                end
                default: res = '0;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_sample(logic [15:0] value, logic clipped);
            wave_sample_t exp_s;
            if (expected_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $error("unexpected output transaction: wave_value %0d clipped %0b",
                           $signed(value), clipped);
                errors++;
                return;
            end
            exp_s = expected_q.pop_front();
            if (value !== exp_s.value)
            begin
                if (errors < MAX_REPORTS)
                    $error("wave_value mismatch: expected %0d, actual %0d",
                           $signed(exp_s.value), $signed(value));
                errors++;
            end
            if (clipped !== exp_s.clipped)
            begin
                if (errors < MAX_REPORTS)
                    $error("clipped mismatch: expected %0b, actual %0b", exp_s.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit                     no_idle;
    wave_scoreboard         sb;

    reference_waveform_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Keep the low bits of a field, fill the rest of the word with noise
    function automatic logic [31:0] rand_above(logic [31:0] value, int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        return ($urandom() & ~mask) | (value & mask);
    endfunction

    // Write one register; starts and ends at a falling edge
    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one sample tick; entered at a falling edge, returns at one
    task automatic send_sample(logic [31:0] sample_index);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample_index;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(sample_index);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted sample has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Output ready: random stalls of random length
    initial
    begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Check every output transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tuser[0]);
    end

    // Hard stop on a hang
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          total;
        int          len;
        int          r;
        bit          sequential;
        bit          first;
        logic [31:0] base;
        logic [31:0] idx;
        logic [31:0] val;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_WAVE_MODE;
        cfg_data  = '0;
        no_idle   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Sine quadrant boundaries at full amplitude
        write_reg(REG_WAVE_MODE, 32'(MODE_SINE));
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
        write_reg(REG_DC_OFFSET, 32'h0000_0000);
        send_sample(32'd0);
        send_sample(32'd1);
        send_sample(32'd2);
        send_sample(32'd3);
        send_sample(32'hFFFF_FFFF);

        // Sine clipping at both rails
        wait_idle();
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_DC_OFFSET, 32'hFFFF_7FFF);
        send_sample(32'hBFFF_FFFF);
        wait_idle();
        write_reg(REG_DC_OFFSET, 32'h0000_8000);
        send_sample(32'h3FFF_FFFF);

        // Unused mode gives zero; spare indexes are dropped
        wait_idle();
        write_reg(REG_WAVE_MODE, {30'h3FFF_FFFF, MODE_UNUSED});
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h5A5A_A5A5);
        send_sample(32'hFFFF_FFFF);

        // Square wave with a zero period, then a period of one
        wait_idle();
        write_reg(REG_WAVE_MODE, 32'(MODE_SQUARE));
        write_reg(REG_PERIOD_STEPS, 32'h0000_0000);
        repeat (3) send_sample($urandom());
        wait_idle();
        write_reg(REG_PERIOD_STEPS, 32'h0000_0001);
        repeat (3) send_sample($urandom());

        // Sawtooth: masked period, ramp saturation, restart past the period
        wait_idle();
        write_reg(REG_WAVE_MODE, 32'(MODE_SAW));
        write_reg(REG_PERIOD_STEPS, 32'hFF00_0005);
        write_reg(REG_RAMP_STEP, 32'h00FF_FFFF);
        write_reg(REG_DC_OFFSET, 32'h0000_0000);
        repeat (7) send_sample($urandom());

        // Random phases with random settings
        total = 0;
        first = 1'b1;
        while (total < RANDOM_ITEMS)
        begin
            wait_idle();
            no_idle = ($urandom_range(0, 4) == 0);

            if (first || $urandom_range(0, 3) != 0)
            begin
                r = $urandom_range(0, 9);
                val = 32'((r < 3) ? MODE_SINE : (r < 6) ? MODE_SQUARE : (r < 9) ? MODE_SAW
                                                                               : MODE_UNUSED);
                write_reg(REG_WAVE_MODE, rand_above(val, 2));
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 9);
                val = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : (r == 2) ? 32'h00FF_FFFF :
                      (r == 3) ? ($urandom() & 32'h00FF_FFFF) : $urandom_range(2, 40);
                write_reg(REG_PERIOD_STEPS, rand_above(val, 24));
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 9);
                val = (r == 0) ? 32'd0 : (r == 1) ? 32'h00FF_FFFF :
                      (r < 6) ? ($urandom() & 32'h00FF_FFFF) : $urandom_range(0, 32'h000F_FFFF);
                write_reg(REG_RAMP_STEP, rand_above(val, 24));
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 9);
                val = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
                write_reg(REG_PHASE_STEP, val);
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 9);
                val = (r == 0) ? 32'd0 : (r == 1) ? 32'h7FFF : ($urandom() & 32'h7FFF);
                write_reg(REG_AMPLITUDE, rand_above(val, 15));
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(0, 9);
                val = (r == 0) ? 32'h7FFF : (r == 1) ? 32'h8000 : (r == 2) ? 32'd0
                                                                 : ($urandom() & 32'hFFFF);
                write_reg(REG_DC_OFFSET, rand_above(val, 16));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
            first = 1'b0;

            // Stream one run of ticks: counting indexes or scattered ones
            len        = $urandom_range(10, 60);
            sequential = $urandom_range(0, 1);
            base       = $urandom();
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 49);
                if (r == 0)
                    wait_idle();
                if (sequential)
                    idx = base + i;
                else if (r == 1)
                    idx = 32'd0;
                else if (r == 2)
                    idx = 32'hFFFF_FFFF;
                else
                    idx = $urandom();
                send_sample(idx);
            end
            total += len;
        end

        // Drain and report
        no_idle = 1'b0;
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule : tb_reference_waveform_generator
